// File: hw/rtl/tcde_pkg.sv
// Shared types and constants for the tab column decimal extractor.
// Depends on nothing; used by tcde_core and tab_column_decimal_extractor_unit.
`default_nettype none

package tcde_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned SKIP_W    = 31;
	localparam int unsigned TABS_W    = 4;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_W     = 32;

	localparam logic [BYTE_W-1:0]  LF_CHAR   = 8'h0a;
	localparam logic [BYTE_W-1:0]  TAB_CHAR  = 8'h09;
	localparam logic [VALUE_W-1:0] ZERO_CHAR = 32'd48;

	// Register indexes of the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SKIP_BYTES   = 8'd0,
		REG_TABS_TO_SKIP = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SKIP_W-1:0] skip_bytes;
		logic [TABS_W-1:0] tabs_to_skip;
	} cfg_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] field_value;
		logic [VALUE_W-1:0]        line_index;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcde_core.sv
// Line and column parser: skip counter, line state, tab count and decimal fold.
// Depends on tcde_pkg; instantiated by tab_column_decimal_extractor_unit.
`default_nettype none

module tcde_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [tcde_pkg::BYTE_W-1:0]   data_byte,
	input  wire tcde_pkg::cfg_t                cfg,
	output tcde_pkg::result_t                  res
);

	logic [tcde_pkg::SKIP_W-1:0]  consumed_q, consumed_n;
	logic                         open_q, open_n;
	logic [tcde_pkg::TABS_W-1:0]  tabs_q, tabs_n;
	logic                         done_q, done_n;
	logic [tcde_pkg::VALUE_W-1:0] acc_q, acc_n;
	logic [tcde_pkg::VALUE_W-1:0] lines_q, lines_n;
	logic [tcde_pkg::VALUE_W-1:0] digit;
	logic                         is_lf, is_tab;
	logic                         hit;

	assign is_lf  = (data_byte == tcde_pkg::LF_CHAR);
	assign is_tab = (data_byte == tcde_pkg::TAB_CHAR);
	// No digit check: any byte folds, wrapping modulo 2^32.
	assign digit  = {{(tcde_pkg::VALUE_W-tcde_pkg::BYTE_W){1'b0}}, data_byte}
		- tcde_pkg::ZERO_CHAR;

	always_comb begin
		consumed_n = consumed_q;
		open_n     = open_q;
		tabs_n     = tabs_q;
		done_n     = done_q;
		acc_n      = acc_q;
		lines_n    = lines_q;
		hit        = 1'b0;
		if (consumed_q < cfg.skip_bytes) begin
			consumed_n = consumed_q + 1'b1;
		end else if (!open_q) begin
			if (is_lf) begin
				open_n = 1'b1;
				tabs_n = '0;
				done_n = 1'b0;
				acc_n  = '0;
			end
		end else if (is_lf) begin
			lines_n = lines_q + 1'b1;
			tabs_n  = '0;
			done_n  = 1'b0;
			acc_n   = '0;
		end else if (!done_q) begin
			if (is_tab) begin
				if (tabs_q < cfg.tabs_to_skip) begin
					tabs_n = tabs_q + 1'b1;
				end else begin
					done_n = 1'b1;
					hit    = 1'b1;
				end
			end else if (tabs_q == cfg.tabs_to_skip) begin
				acc_n = (acc_q << 3) + (acc_q << 1) + digit;
			end
		end
	end

	assign res.hit         = hit;
	assign res.field_value = acc_q;
	assign res.line_index  = lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= '0;
			open_q     <= 1'b0;
			tabs_q     <= '0;
			done_q     <= 1'b0;
			acc_q      <= '0;
			lines_q    <= '0;
		end else if (step) begin
			consumed_q <= consumed_n;
			open_q     <= open_n;
			tabs_q     <= tabs_n;
			done_q     <= done_n;
			acc_q      <= acc_n;
			lines_q    <= lines_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tab_column_decimal_extractor_unit.sv
// Top level of the tab column decimal extractor: stream ports, config registers,
// input stage and result register. Depends on tcde_pkg and tcde_core.
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    s_tdata  = data_byte
//   m_*       out  m_tvalid / m_tready    m_tdata  = field_value, line_index
//   cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte beat per cycle sustained when not stalled; a closing tab is accepted
// into the input stage, which feeds the result register directly.
// The parse state updates once per byte in a single stage, so the rate is set
// by that update of counter, compare and multiply-by-ten add.
// Reset (arst_n low) clears all control state; no clearing pass is needed.
// s_tready drops only when the staged byte yields a result while the result
// register is full and m_tready is low; bytes without a result never stall.
`default_nettype none

module tab_column_decimal_extractor_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [63:0]                           m_tdata,   // [31:0] field_value,
	                                                         // [63:32] line_index
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tcde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tcde_pkg::CFG_W-1:0]       cfg_data
);

	tcde_pkg::cfg_t    cfg_q;
	tcde_pkg::result_t res;

	logic                        valid_s1;
	logic [tcde_pkg::BYTE_W-1:0] data_s1;
	logic                        stall;
	logic                        step;
	logic                        load_out;
	logic                        out_valid_q;
	logic [63:0]                 out_data_q;

	// Config writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.skip_bytes   <= '0;
			cfg_q.tabs_to_skip <= tcde_pkg::TABS_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				tcde_pkg::REG_SKIP_BYTES:   cfg_q.skip_bytes   <= cfg_data[tcde_pkg::SKIP_W-1:0];
				tcde_pkg::REG_TABS_TO_SKIP: cfg_q.tabs_to_skip <= cfg_data[tcde_pkg::TABS_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the staged byte only when its result has nowhere to go.
	assign stall    = valid_s1 && res.hit && out_valid_q && !m_tready;
	assign step     = valid_s1 && !stall;
	assign load_out = step && res.hit;
	assign s_tready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	tcde_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Result register: load on a closing tab, drop once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {res.line_index, res.field_value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Back-pressure on the input only comes from a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	// A held byte keeps its value until it is processed.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s_tready) |=> (valid_s1 && $stable(data_s1)))
		else $error("staged byte changed while stalled");

	// A loaded result is always presented in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("result loaded but not presented");

	// Never overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
